FILE: design/multilevel_feedback_queue_core_defines.svh
// Assertion macros used by the scheduler back end.
// Each macro expects signals clk and rst_n in the scope where it is used.
`ifndef MULTILEVEL_FEEDBACK_QUEUE_CORE_DEFINES_SVH
`define MULTILEVEL_FEEDBACK_QUEUE_CORE_DEFINES_SVH

// Property that holds at every clock edge out of reset
`define MLFQ_ASSERT_ALWAYS(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// Same-cycle implication
`define MLFQ_ASSERT_IMPLIES(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

`endif

FILE: design/mlfq_pkg.sv
// Shared types and constants of the multilevel feedback queue scheduler.
// No dependencies.
package mlfq_pkg;

  localparam int NUM_LEVELS = 3;
  localparam int LVL_W      = 2;
  localparam int TIME_W     = 32;
  localparam int PID_MAX_W  = 16;
  localparam int IN_PID_W   = 8;
  localparam int SLOT_OUT_W = 4;

  // Command codes
  localparam logic [1:0] CMD_ADD     = 2'd0;
  localparam logic [1:0] CMD_DELETE  = 2'd1;
  localparam logic [1:0] CMD_REQUEUE = 2'd2;
  localparam logic [1:0] CMD_NOP     = 2'd3;

  // Requeue modes
  localparam logic [1:0] MODE_RANDOM  = 2'd0;
  localparam logic [1:0] MODE_STATIC  = 2'd1;

  // Status codes
  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_FULL      = 2'd1;
  localparam logic [1:0] ST_NOT_FOUND = 2'd2;
  localparam logic [1:0] ST_EMPTY     = 2'd3;

  localparam logic [1:0] LVL_HIGH = 2'd0;
  localparam logic [1:0] LVL_LOW  = 2'd2;

  // One classified command, passed from front to back
  typedef struct packed {
    logic [1:0]           cmd;
    logic [LVL_W-1:0]     lvl;
    logic [LVL_W-1:0]     new_lvl;
    logic [PID_MAX_W-1:0] pid;
    logic [TIME_W-1:0]    stime;
  } job_t;

  // Clamp an out-of-range level to the low level
  function automatic logic [LVL_W-1:0] sat_level(input logic [LVL_W-1:0] v);
    return (v > LVL_LOW) ? LVL_LOW : v;
  endfunction

endpackage

FILE: design/multilevel_feedback_queue_core.sv
// Add walks the target level to its first free slot; delete walks the slots until the id is
// found; requeue does at most one free-slot walk. The back-end sequencer's slot walks set
// the rate, the free-slot walk taking one slot a cycle; one command at a time is executed,
// while a two-entry queue lets the front accept two more.
// Synchronous active-low reset empties all levels, zeroes the id counter, sets mode to static.
// Results are strobed for one cycle and cannot be stalled.
module multilevel_feedback_queue_core
  import mlfq_pkg::*;
#(
  parameter int QUEUE_DEPTH = 16,
  parameter int PID_BITS    = 8
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  output logic                  busy,
  input  logic [1:0]            in_command,
  input  logic [LVL_W-1:0]      in_level,
  input  logic [IN_PID_W-1:0]   in_target_pid,
  input  logic [LVL_W-1:0]      in_random_level,
  input  logic [TIME_W-1:0]     in_start_time,
  output logic                  out_valid,
  output logic [1:0]            out_status,
  output logic [IN_PID_W-1:0]   out_pid,
  output logic [LVL_W-1:0]      out_level_out,
  output logic [SLOT_OUT_W-1:0] out_slot,
  output logic [TIME_W-1:0]     out_entry_time,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [1:0]            cfg_requeue_mode
);

  localparam int SLOT_W = $clog2(QUEUE_DEPTH);

  job_t                       push_job;
  job_t                       head_job;
  logic                       push;
  logic                       pop;
  logic                       full;
  logic                       empty;
  logic [PID_BITS-1:0]        pid_int;
  logic [SLOT_W-1:0]          slot_int;
  logic [PID_BITS+IN_PID_W-1:0]  pid_ext;
  logic [SLOT_W+SLOT_OUT_W-1:0]  slot_ext;

  mlfq_front #(.PID_BITS(PID_BITS)) u_front (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .busy             (busy),
    .in_command       (in_command),
    .in_level         (in_level),
    .in_target_pid    (in_target_pid),
    .in_random_level  (in_random_level),
    .in_start_time    (in_start_time),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_requeue_mode (cfg_requeue_mode),
    .fifo_full        (full),
    .push             (push),
    .job              (push_job)
  );

  mlfq_cmd_fifo u_fifo (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (push),
    .din   (push_job),
    .pop   (pop),
    .dout  (head_job),
    .full  (full),
    .empty (empty)
  );

  mlfq_back #(.QUEUE_DEPTH(QUEUE_DEPTH), .PID_BITS(PID_BITS)) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .job_valid  (!empty),
    .job        (head_job),
    .job_pop    (pop),
    .out_valid  (out_valid),
    .out_status (out_status),
    .out_pid    (pid_int),
    .out_level  (out_level_out),
    .out_slot   (slot_int),
    .out_time   (out_entry_time)
  );

  // Fit internal id and slot widths to the result ports
  assign pid_ext  = {{IN_PID_W{1'b0}}, pid_int};
  assign slot_ext = {{SLOT_OUT_W{1'b0}}, slot_int};
  assign out_pid  = pid_ext[IN_PID_W-1:0];
  assign out_slot = slot_ext[SLOT_OUT_W-1:0];

endmodule

FILE: design/mlfq_front.sv
// Front end: accepts commands, assigns process ids, picks the requeue level.
// Depends on mlfq_pkg.
module mlfq_front
  import mlfq_pkg::*;
#(
  parameter int PID_BITS = 8
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  logic [1:0]          in_command,
  input  logic [LVL_W-1:0]    in_level,
  input  logic [IN_PID_W-1:0] in_target_pid,
  input  logic [LVL_W-1:0]    in_random_level,
  input  logic [TIME_W-1:0]   in_start_time,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [1:0]          cfg_requeue_mode,
  input  logic                fifo_full,
  output logic                push,
  output job_t                job
);

  logic [PID_BITS-1:0]          next_id_r, next_id_nxt;
  logic [1:0]                   mode_r;
  logic                         accept;
  logic [LVL_W-1:0]             lvl;
  logic [LVL_W-1:0]             rlvl;
  logic [PID_BITS+IN_PID_W-1:0] target_ext;
  logic [PID_BITS-1:0]          pid_sel;
  logic [PID_BITS+PID_MAX_W-1:0] pid_ext;

  assign busy      = fifo_full;
  assign cfg_ready = 1'b1;
  assign accept    = start && !busy;
  assign push      = accept && (in_command != CMD_NOP);

  assign lvl        = sat_level(in_level);
  assign rlvl       = sat_level(in_random_level);
  assign target_ext = {{PID_BITS{1'b0}}, in_target_pid};
  assign pid_sel    = (in_command == CMD_ADD) ? next_id_r : target_ext[PID_BITS-1:0];
  assign pid_ext    = {{PID_MAX_W{1'b0}}, pid_sel};

  // Classify the transaction
  always_comb begin
    job.cmd   = in_command;
    job.lvl   = lvl;
    job.pid   = pid_ext[PID_MAX_W-1:0];
    job.stime = in_start_time;
    if (mode_r == MODE_RANDOM) begin
      job.new_lvl = rlvl;
    end else if (mode_r == MODE_STATIC) begin
      job.new_lvl = lvl;
    end else begin
      job.new_lvl = (lvl == LVL_LOW) ? LVL_LOW : lvl + 2'd1;
    end
  end

  // Advance the id on every accepted add, full or not
  assign next_id_nxt = (accept && in_command == CMD_ADD) ? next_id_r + PID_BITS'(1) : next_id_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      next_id_r <= '0;
      mode_r    <= MODE_STATIC;
    end else begin
      next_id_r <= next_id_nxt;
      if (cfg_valid && cfg_ready) begin
        mode_r <= cfg_requeue_mode;
      end
    end
  end

endmodule

FILE: design/mlfq_cmd_fifo.sv
// Two-entry command queue between front and back.
// Depends on mlfq_pkg.
module mlfq_cmd_fifo
  import mlfq_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  job_t din,
  input  logic pop,
  output job_t dout,
  output logic full,
  output logic empty
);

  job_t       mem_r [2];
  logic       wr_ptr_r;
  logic       rd_ptr_r;
  logic [1:0] cnt_r, cnt_nxt;

  assign full  = (cnt_r == 2'd2);
  assign empty = (cnt_r == 2'd0);
  assign dout  = mem_r[rd_ptr_r];

  assign cnt_nxt = cnt_r + {1'b0, push} - {1'b0, pop};

  // Store pushed entries
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= din;
    end
  end

  // Advance pointers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      if (push) wr_ptr_r <= !wr_ptr_r;
      if (pop)  rd_ptr_r <= !rd_ptr_r;
      cnt_r <= cnt_nxt;
    end
  end

endmodule

FILE: design/mlfq_back.sv
// Back end: slot table, linked-list queues and the command sequencer.
// Depends on mlfq_pkg and multilevel_feedback_queue_core_defines.svh.
`include "multilevel_feedback_queue_core_defines.svh"
module mlfq_back
  import mlfq_pkg::*;
#(
  parameter int QUEUE_DEPTH = 16,
  parameter int PID_BITS    = 8
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                job_valid,
  input  job_t                job,
  output logic                job_pop,
  output logic                out_valid,
  output logic [1:0]          out_status,
  output logic [PID_BITS-1:0] out_pid,
  output logic [LVL_W-1:0]    out_level,
  output logic [$clog2(QUEUE_DEPTH)-1:0] out_slot,
  output logic [TIME_W-1:0]   out_time
);

  localparam int SLOT_W = $clog2(QUEUE_DEPTH);
  localparam int LINK_W = SLOT_W + 1;
  localparam int TOTAL  = NUM_LEVELS * QUEUE_DEPTH;
  localparam int ADDR_W = $clog2(TOTAL);
  localparam int CNT_W  = $clog2(QUEUE_DEPTH + 1);
  localparam logic [LINK_W-1:0] NONE = {1'b1, {SLOT_W{1'b0}}};
  localparam logic [SLOT_W-1:0] LAST = SLOT_W'(QUEUE_DEPTH - 1);

  typedef enum logic [7:0] {
    S_IDLE   = 8'b00000001,
    S_SCAN   = 8'b00000010,
    S_DSCAN  = 8'b00000100,
    S_DCMP   = 8'b00001000,
    S_RREAD  = 8'b00010000,
    S_UNLINK = 8'b00100000,
    S_APP1   = 8'b01000000,
    S_APP2   = 8'b10000000
  } state_t;

  function automatic logic [ADDR_W-1:0] ent_addr(input logic [LVL_W-1:0] l,
                                                 input logic [SLOT_W-1:0] s);
    return ADDR_W'(ADDR_W'(l) * ADDR_W'(QUEUE_DEPTH)) + ADDR_W'(s);
  endfunction

  // Slot table memories
  logic [PID_BITS-1:0] pid_mem  [TOTAL];
  logic [TIME_W-1:0]   time_mem [TOTAL];
  logic [LINK_W-1:0]   prev_mem [TOTAL];
  logic [LINK_W-1:0]   next_mem [TOTAL];

  logic [PID_BITS-1:0] pid_q;
  logic [TIME_W-1:0]   time_q;
  logic [LINK_W-1:0]   prev_q;
  logic [LINK_W-1:0]   next_q;

  logic                rd_en;
  logic [ADDR_W-1:0]   rd_addr;
  logic                ent_we;
  logic [ADDR_W-1:0]   ent_wa;
  logic                prev_we;
  logic [ADDR_W-1:0]   prev_wa;
  logic [LINK_W-1:0]   prev_wd;
  logic                next_we;
  logic [ADDR_W-1:0]   next_wa;
  logic [LINK_W-1:0]   next_wd;

  state_t              state_r, state_nxt;
  logic [1:0]          op_r, op_nxt;
  logic [LVL_W-1:0]    lvl_r, lvl_nxt;
  logic [LVL_W-1:0]    new_lvl_r, new_lvl_nxt;
  logic [PID_BITS-1:0] pid_r, pid_nxt;
  logic [TIME_W-1:0]   time_r, time_nxt;
  logic [SLOT_W-1:0]   slot_r, slot_nxt;
  logic [SLOT_W-1:0]   scan_cnt_r, scan_cnt_nxt;
  logic [LVL_W-1:0]    scan_lvl_r, scan_lvl_nxt;
  logic                moved_r, moved_nxt;
  logic [LVL_W-1:0]    app_lvl_r, app_lvl_nxt;
  logic [SLOT_W-1:0]   app_slot_r, app_slot_nxt;
  logic [LINK_W-1:0]   app_tail_r, app_tail_nxt;
  logic [TOTAL-1:0]    valid_r, valid_nxt;
  logic [LINK_W-1:0]   head_r  [NUM_LEVELS];
  logic [LINK_W-1:0]   head_nxt[NUM_LEVELS];
  logic [LINK_W-1:0]   tail_r  [NUM_LEVELS];
  logic [LINK_W-1:0]   tail_nxt[NUM_LEVELS];
  logic [CNT_W-1:0]    count_r [NUM_LEVELS];
  logic [CNT_W-1:0]    count_nxt[NUM_LEVELS];

  logic                out_valid_r, out_valid_nxt;
  logic [1:0]          out_status_r, out_status_nxt;
  logic [PID_BITS-1:0] out_pid_r, out_pid_nxt;
  logic [LVL_W-1:0]    out_level_r, out_level_nxt;
  logic [SLOT_W-1:0]   out_slot_r, out_slot_nxt;
  logic [TIME_W-1:0]   out_time_r, out_time_nxt;

  logic [LINK_W-1:0]   job_head;

  assign job_head   = head_r[job.lvl];
  assign out_valid  = out_valid_r;
  assign out_status = out_status_r;
  assign out_pid    = out_pid_r;
  assign out_level  = out_level_r;
  assign out_slot   = out_slot_r;
  assign out_time   = out_time_r;

  // Sequencer
  always_comb begin
    state_nxt      = state_r;
    op_nxt         = op_r;
    lvl_nxt        = lvl_r;
    new_lvl_nxt    = new_lvl_r;
    pid_nxt        = pid_r;
    time_nxt       = time_r;
    slot_nxt       = slot_r;
    scan_cnt_nxt   = scan_cnt_r;
    scan_lvl_nxt   = scan_lvl_r;
    moved_nxt      = moved_r;
    app_lvl_nxt    = app_lvl_r;
    app_slot_nxt   = app_slot_r;
    app_tail_nxt   = app_tail_r;
    valid_nxt      = valid_r;
    head_nxt       = head_r;
    tail_nxt       = tail_r;
    count_nxt      = count_r;
    out_valid_nxt  = 1'b0;
    out_status_nxt = out_status_r;
    out_pid_nxt    = out_pid_r;
    out_level_nxt  = out_level_r;
    out_slot_nxt   = out_slot_r;
    out_time_nxt   = out_time_r;
    job_pop        = 1'b0;
    rd_en          = 1'b0;
    rd_addr        = '0;
    ent_we         = 1'b0;
    ent_wa         = '0;
    prev_we        = 1'b0;
    prev_wa        = '0;
    prev_wd        = '0;
    next_we        = 1'b0;
    next_wa        = '0;
    next_wd        = '0;

    case (state_r)
      S_IDLE: begin
        if (job_valid) begin
          job_pop     = 1'b1;
          op_nxt      = job.cmd;
          lvl_nxt     = job.lvl;
          new_lvl_nxt = job.new_lvl;
          pid_nxt     = job.pid[PID_BITS-1:0];
          time_nxt    = job.stime;
          moved_nxt   = 1'b0;
          case (job.cmd)
            CMD_ADD: begin
              scan_lvl_nxt = job.lvl;
              scan_cnt_nxt = '0;
              state_nxt    = S_SCAN;
            end
            CMD_DELETE: begin
              slot_nxt  = '0;
              lvl_nxt   = LVL_HIGH;
              state_nxt = S_DSCAN;
            end
            CMD_REQUEUE: begin
              if (job_head[SLOT_W] ||
                  !valid_r[ent_addr(job.lvl, job_head[SLOT_W-1:0])]) begin
                out_valid_nxt  = 1'b1;
                out_status_nxt = ST_EMPTY;
                out_pid_nxt    = '0;
                out_level_nxt  = job.lvl;
                out_slot_nxt   = '0;
                out_time_nxt   = '0;
              end else begin
                rd_en     = 1'b1;
                rd_addr   = ent_addr(job.lvl, job_head[SLOT_W-1:0]);
                slot_nxt  = job_head[SLOT_W-1:0];
                state_nxt = S_RREAD;
              end
            end
            default: ;
          endcase
        end
      end

      // Walk one slot a cycle looking for a free one
      S_SCAN: begin
        if (!valid_r[ent_addr(scan_lvl_r, scan_cnt_r)]) begin
          app_lvl_nxt  = scan_lvl_r;
          app_slot_nxt = scan_cnt_r;
          state_nxt    = (op_r == CMD_REQUEUE && !moved_r) ? S_UNLINK : S_APP1;
        end else if (scan_cnt_r == LAST) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = ST_FULL;
          out_pid_nxt    = pid_r;
          out_level_nxt  = lvl_r;
          out_slot_nxt   = (op_r == CMD_ADD) ? '0 : slot_r;
          out_time_nxt   = time_r;
          state_nxt      = S_IDLE;
        end else begin
          scan_cnt_nxt = scan_cnt_r + SLOT_W'(1);
        end
      end

      // Delete search: slot major, level minor
      S_DSCAN, S_DCMP: begin
        if (state_r == S_DSCAN && valid_r[ent_addr(lvl_r, slot_r)]) begin
          rd_en     = 1'b1;
          rd_addr   = ent_addr(lvl_r, slot_r);
          state_nxt = S_DCMP;
        end else if (state_r == S_DCMP && pid_q == pid_r) begin
          time_nxt  = time_q;
          state_nxt = S_UNLINK;
        end else begin
          state_nxt = S_DSCAN;
          if (lvl_r == LVL_LOW) begin
            lvl_nxt = LVL_HIGH;
            if (slot_r == LAST) begin
              out_valid_nxt  = 1'b1;
              out_status_nxt = ST_NOT_FOUND;
              out_pid_nxt    = pid_r;
              out_level_nxt  = LVL_HIGH;
              out_slot_nxt   = '0;
              out_time_nxt   = '0;
              state_nxt      = S_IDLE;
            end else begin
              slot_nxt = slot_r + SLOT_W'(1);
            end
          end else begin
            lvl_nxt = lvl_r + 2'd1;
          end
        end
      end

      // Head entry read back; check the target level first when it differs
      S_RREAD: begin
        pid_nxt  = pid_q;
        time_nxt = time_q;
        if (new_lvl_r != lvl_r) begin
          scan_lvl_nxt = new_lvl_r;
          scan_cnt_nxt = '0;
          state_nxt    = S_SCAN;
        end else begin
          state_nxt = S_UNLINK;
        end
      end

      // Drop the entry from its list
      S_UNLINK: begin
        valid_nxt[ent_addr(lvl_r, slot_r)] = 1'b0;
        if (prev_q[SLOT_W]) begin
          head_nxt[lvl_r] = next_q;
        end else begin
          next_we = 1'b1;
          next_wa = ent_addr(lvl_r, prev_q[SLOT_W-1:0]);
          next_wd = next_q;
        end
        if (next_q[SLOT_W]) begin
          tail_nxt[lvl_r] = prev_q;
        end else begin
          prev_we = 1'b1;
          prev_wa = ent_addr(lvl_r, next_q[SLOT_W-1:0]);
          prev_wd = prev_q;
        end
        count_nxt[lvl_r] = count_r[lvl_r] - CNT_W'(1);
        moved_nxt        = 1'b1;
        if (op_r == CMD_DELETE) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = ST_OK;
          out_pid_nxt    = pid_r;
          out_level_nxt  = lvl_r;
          out_slot_nxt   = slot_r;
          out_time_nxt   = time_r;
          state_nxt      = S_IDLE;
        end else if (new_lvl_r != lvl_r) begin
          state_nxt = S_APP1;
        end else begin
          scan_lvl_nxt = new_lvl_r;
          scan_cnt_nxt = '0;
          state_nxt    = S_SCAN;
        end
      end

      // Write the new entry and move the tail
      S_APP1: begin
        ent_we  = 1'b1;
        ent_wa  = ent_addr(app_lvl_r, app_slot_r);
        prev_we = 1'b1;
        prev_wa = ent_addr(app_lvl_r, app_slot_r);
        prev_wd = tail_r[app_lvl_r];
        next_we = 1'b1;
        next_wa = ent_addr(app_lvl_r, app_slot_r);
        next_wd = NONE;
        valid_nxt[ent_addr(app_lvl_r, app_slot_r)] = 1'b1;
        count_nxt[app_lvl_r] = count_r[app_lvl_r] + CNT_W'(1);
        if (tail_r[app_lvl_r][SLOT_W]) begin
          head_nxt[app_lvl_r] = {1'b0, app_slot_r};
        end
        tail_nxt[app_lvl_r] = {1'b0, app_slot_r};
        app_tail_nxt        = tail_r[app_lvl_r];
        state_nxt           = S_APP2;
      end

      // Link the old tail forward and report
      S_APP2: begin
        if (!app_tail_r[SLOT_W]) begin
          next_we = 1'b1;
          next_wa = ent_addr(app_lvl_r, app_tail_r[SLOT_W-1:0]);
          next_wd = {1'b0, app_slot_r};
        end
        out_valid_nxt  = 1'b1;
        out_status_nxt = ST_OK;
        out_pid_nxt    = pid_r;
        out_level_nxt  = app_lvl_r;
        out_slot_nxt   = app_slot_r;
        out_time_nxt   = time_r;
        state_nxt      = S_IDLE;
      end

      default: state_nxt = S_IDLE;
    endcase
  end

  // Slot table memories, registered read
  always_ff @(posedge clk) begin
    if (ent_we) begin
      pid_mem[ent_wa]  <= pid_r;
      time_mem[ent_wa] <= time_r;
    end
    if (prev_we) prev_mem[prev_wa] <= prev_wd;
    if (next_we) next_mem[next_wa] <= next_wd;
    if (rd_en) begin
      pid_q  <= pid_mem[rd_addr];
      time_q <= time_mem[rd_addr];
      prev_q <= prev_mem[rd_addr];
      next_q <= next_mem[rd_addr];
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    op_r         <= op_nxt;
    lvl_r        <= lvl_nxt;
    new_lvl_r    <= new_lvl_nxt;
    pid_r        <= pid_nxt;
    time_r       <= time_nxt;
    slot_r       <= slot_nxt;
    scan_cnt_r   <= scan_cnt_nxt;
    scan_lvl_r   <= scan_lvl_nxt;
    moved_r      <= moved_nxt;
    app_lvl_r    <= app_lvl_nxt;
    app_slot_r   <= app_slot_nxt;
    app_tail_r   <= app_tail_nxt;
    out_status_r <= out_status_nxt;
    out_pid_r    <= out_pid_nxt;
    out_level_r  <= out_level_nxt;
    out_slot_r   <= out_slot_nxt;
    out_time_r   <= out_time_nxt;
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      valid_r     <= '0;
      out_valid_r <= 1'b0;
      for (int i = 0; i < NUM_LEVELS; i++) begin
        head_r[i]  <= NONE;
        tail_r[i]  <= NONE;
        count_r[i] <= '0;
      end
    end else begin
      state_r     <= state_nxt;
      valid_r     <= valid_nxt;
      out_valid_r <= out_valid_nxt;
      head_r      <= head_nxt;
      tail_r      <= tail_nxt;
      count_r     <= count_nxt;
    end
  end

  `MLFQ_ASSERT_ALWAYS(a_count_matches_valid, (count_r[0] == CNT_W'($countones(valid_r[0 +: QUEUE_DEPTH]))) && (count_r[1] == CNT_W'($countones(valid_r[QUEUE_DEPTH +: QUEUE_DEPTH]))) && (count_r[2] == CNT_W'($countones(valid_r[2*QUEUE_DEPTH +: QUEUE_DEPTH]))), "level count disagrees with valid slots")
  `MLFQ_ASSERT_ALWAYS(a_head_tail_agree, (head_r[0][SLOT_W] == tail_r[0][SLOT_W]) && (head_r[1][SLOT_W] == tail_r[1][SLOT_W]) && (head_r[2][SLOT_W] == tail_r[2][SLOT_W]), "head and tail disagree on empty list")
  `MLFQ_ASSERT_ALWAYS(a_head_empty, (head_r[0][SLOT_W] == (count_r[0] == '0)) && (head_r[1][SLOT_W] == (count_r[1] == '0)) && (head_r[2][SLOT_W] == (count_r[2] == '0)), "empty head with nonzero count")
  `MLFQ_ASSERT_IMPLIES(a_unlink_nonempty, state_r == S_UNLINK, count_r[lvl_r] != '0, "unlink from empty level")

endmodule
